>>> rtl/tpbd_pkg.sv
package tpbd_pkg;

    // Sample and result widths
    localparam int SAMPLE_W  = 16;
    localparam int GCOUNT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_COUNT  = 2'd2;

    // Word kinds on tuser
    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV
    } t_state;

    // Control fields used by every sort cell
    typedef struct packed {
        logic load;      // calibration word inserted this cycle
        logic occupied;  // cell holds a value of the current set
        logic at_end;    // cell is the first free slot
    } t_cell_ctl;

endpackage

>>> rtl/tpbd_sort_cell.sv
module tpbd_sort_cell (
    input  logic                          i_clk,
    input  tpbd_pkg::t_cell_ctl           i_ctl,
    input  logic [tpbd_pkg::SAMPLE_W-1:0] i_value,
    input  logic                          i_prev_gt,
    input  logic [tpbd_pkg::SAMPLE_W-1:0] i_prev_val,
    output logic                          o_gt,
    output logic [tpbd_pkg::SAMPLE_W-1:0] o_val
);
    import tpbd_pkg::*;

    logic [SAMPLE_W-1:0] r_val;
    logic [SAMPLE_W-1:0] n_val;

    // gt: this entry must move up to make room for the new value
    assign o_gt  = i_ctl.occupied && (r_val > i_value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load) begin
            if (i_prev_gt) begin
                n_val = i_prev_val;
            end else if (o_gt || i_ctl.at_end) begin
                n_val = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> rtl/tpbd_const_div.sv
module tpbd_const_div #(
    parameter int DIVISOR    = 6,
    parameter int DIVIDEND_W = 20,
    parameter int QUOT_W     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_done,
    output logic [QUOT_W-1:0]     o_quotient
);
    // reciprocal multiply: floor(x / d) = (x * ceil(2^k / d)) >> k,
    // exact for every x of DIVIDEND_W bits with k = DIVIDEND_W + clog2(d)
    localparam int SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
    localparam int MULT_W = DIVIDEND_W + 1;
    localparam int PROD_W = DIVIDEND_W + MULT_W;
    localparam longint RECIP =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
    localparam logic [MULT_W-1:0] RECIP_M = MULT_W'(RECIP);

    logic                  r_busy;
    logic                  r_done;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [QUOT_W-1:0]     r_quo;
    logic [PROD_W-1:0]     w_prod;

    // dividend registered first, product in the following cycle
    assign w_prod = {{MULT_W{1'b0}}, r_dvd} * {{DIVIDEND_W{1'b0}}, RECIP_M};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        if (r_busy) begin
            r_quo <= w_prod[SHIFT +: QUOT_W];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/touch_pad_baseline_and_detect.sv
// Scan words: one per cycle while o_s_tready is high; the result word is registered.
// Calibration words: one per cycle while o_s_tready is high; the last word of a set holds
//   o_s_tready low for a sweep over the sort cells into the accumulator, then a
//   registered reciprocal multiply for the trimmed mean.
// Reset (i_rst_n low, synchronous): counts, baseline, group state and registers to defaults;
//   the sort cells are not cleared, only entries below the calibration count are used.
module touch_pad_baseline_and_detect #(
    parameter int CAL_SAMPLES    = 10,
    parameter int TRIM_EACH_SIDE = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [15:0]                    i_s_tdata,  // [15:0] sample
    input  logic [1:0]                     i_s_tuser,  // [0] kind, [1] long_scan
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [39:0]                    o_m_tdata,  // [15:0] baseline, [31:16] peak,
                                                       // [32] touched, [39:33] zero
    output logic [0:0]                     o_m_tuser,  // [0] result_kind
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import tpbd_pkg::*;

    localparam int  CNT_W    = $clog2(CAL_SAMPLES + 1);
    localparam int  IDX_W    = $clog2(CAL_SAMPLES);
    localparam int  SUM_W    = SAMPLE_W + $clog2(CAL_SAMPLES);
    localparam bit  TRIM_ALL = (2 * TRIM_EACH_SIDE) >= CAL_SAMPLES;
    // with everything trimmed the sum stays zero, so divide by one
    localparam int  KEPT     = TRIM_ALL ? 1 : CAL_SAMPLES - 2 * TRIM_EACH_SIDE;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [SAMPLE_W-1:0] r_margin, n_margin;
    logic [GCOUNT_W-1:0] r_short, n_short;
    logic [GCOUNT_W-1:0] r_long, n_long;
    logic [CNT_W-1:0]    r_cal_count, n_cal_count;
    logic [SAMPLE_W-1:0] r_baseline, n_baseline;
    logic [SAMPLE_W-1:0] r_gmax, n_gmax;
    logic [GCOUNT_W-1:0] r_gcount, n_gcount;
    logic [GCOUNT_W-1:0] r_gtarget, n_gtarget;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [SUM_W-1:0]    r_acc, n_acc;
    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_kind, n_out_kind;
    logic [SAMPLE_W-1:0] r_out_base, n_out_base;
    logic [SAMPLE_W-1:0] r_out_peak, n_out_peak;
    logic                r_out_touch, n_out_touch;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic                w_s_acc, w_cal_acc, w_scan_acc;
    logic [SAMPLE_W-1:0] w_sample;
    logic                w_kind, w_long;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_sample   = i_s_tdata;
    assign w_kind     = i_s_tuser[0];
    assign w_long     = i_s_tuser[1];
    assign w_cal_acc  = w_s_acc && (w_kind == KIND_CAL);
    assign w_scan_acc = w_s_acc && (w_kind == KIND_SCAN);

    // ---------------------------------------------------------------
    // Sort chain: each cell holds one entry, ascending from cell 0.
    // On insert, cells above the new value take their lower neighbour.
    // ---------------------------------------------------------------
    logic                w_gt  [CAL_SAMPLES];
    logic [SAMPLE_W-1:0] w_val [CAL_SAMPLES];

    genvar gi;
    generate
        for (gi = 0; gi < CAL_SAMPLES; gi++) begin : g_cell
            t_cell_ctl           w_ctl;
            logic                w_prev_gt;
            logic [SAMPLE_W-1:0] w_prev_val;

            assign w_ctl.load     = w_cal_acc;
            assign w_ctl.occupied = CNT_W'(gi) < r_cal_count;
            assign w_ctl.at_end   = CNT_W'(gi) == r_cal_count;

            if (gi == 0) begin : g_first
                assign w_prev_gt  = 1'b0;
                assign w_prev_val = '0;
            end else begin : g_rest
                assign w_prev_gt  = w_gt[gi-1];
                assign w_prev_val = w_val[gi-1];
            end

            tpbd_sort_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_value    (w_sample),
                .i_prev_gt  (w_prev_gt),
                .i_prev_val (w_prev_val),
                .o_gt       (w_gt[gi]),
                .o_val      (w_val[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Trimmed sum sweep and divider
    // ---------------------------------------------------------------
    logic                w_keep;
    logic [SUM_W-1:0]    w_acc_next;
    logic                w_div_start;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_mean;

    assign w_keep = !TRIM_ALL
                 && (r_rd_idx >= IDX_W'(TRIM_EACH_SIDE))
                 && ({1'b0, r_rd_idx} < (IDX_W+1)'(CAL_SAMPLES - TRIM_EACH_SIDE));
    assign w_acc_next = r_acc + (w_keep ? SUM_W'(w_val[r_rd_idx]) : SUM_W'(0));
    assign w_div_start = (r_state == ST_SUM) && (r_rd_idx == IDX_W'(CAL_SAMPLES - 1));

    tpbd_const_div #(
        .DIVISOR    (KEPT),
        .DIVIDEND_W (SUM_W),
        .QUOT_W     (SAMPLE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc_next),
        .o_done     (w_div_done),
        .o_quotient (w_mean)
    );

    // ---------------------------------------------------------------
    // Scan group datapath
    // ---------------------------------------------------------------
    logic [GCOUNT_W-1:0] w_tsel, w_tnow;
    logic [SAMPLE_W-1:0] w_max_now;
    logic [GCOUNT_W:0]   w_cnt_inc;
    logic                w_grp_done;
    logic [SAMPLE_W:0]   w_limit;
    logic                w_touch;

    assign w_tsel     = w_long ? r_long : r_short;
    // a count of zero behaves as one
    assign w_tnow     = (r_gcount != '0) ? r_gtarget
                      : ((w_tsel == '0) ? GCOUNT_W'(1) : w_tsel);
    assign w_max_now  = ((r_gcount == '0) || (w_sample > r_gmax)) ? w_sample : r_gmax;
    assign w_cnt_inc  = {1'b0, r_gcount} + (GCOUNT_W+1)'(1);
    assign w_grp_done = w_cnt_inc >= {1'b0, w_tnow};
    // no wrap: compare at 17 bits
    assign w_limit    = {1'b0, r_baseline} + {1'b0, r_margin};
    assign w_touch    = {1'b0, w_max_now} > w_limit;

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_margin    = r_margin;
        n_short     = r_short;
        n_long      = r_long;
        n_cal_count = r_cal_count;
        n_baseline  = r_baseline;
        n_gmax      = r_gmax;
        n_gcount    = r_gcount;
        n_gtarget   = r_gtarget;
        n_rd_idx    = r_rd_idx;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_base  = r_out_base;
        n_out_peak  = r_out_peak;
        n_out_touch = r_out_touch;

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GATE_MARGIN: n_margin = i_cfg_data;
                REG_SHORT_COUNT: n_short  = i_cfg_data[GCOUNT_W-1:0];
                REG_LONG_COUNT:  n_long   = i_cfg_data[GCOUNT_W-1:0];
                default: ;
            endcase
        end

        // scan group, independent of calibration
        if (w_scan_acc) begin
            if (w_grp_done) begin
                n_gcount    = '0;
                n_gmax      = '0;
                n_gtarget   = w_tnow;
                n_out_valid = 1'b1;
                n_out_kind  = KIND_SCAN;
                n_out_base  = r_baseline;
                n_out_peak  = w_max_now;
                n_out_touch = w_touch;
            end else begin
                n_gcount  = w_cnt_inc[GCOUNT_W-1:0];
                n_gmax    = w_max_now;
                n_gtarget = w_tnow;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_cal_acc) begin
                    if (r_cal_count == CNT_W'(CAL_SAMPLES - 1)) begin
                        n_cal_count = '0;
                        n_rd_idx    = '0;
                        n_acc       = '0;
                        n_state     = ST_SUM;
                    end else begin
                        n_cal_count = r_cal_count + CNT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                n_acc    = w_acc_next;
                n_rd_idx = r_rd_idx + IDX_W'(1);
                if (w_div_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_baseline  = w_mean;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_CAL;
                    n_out_base  = w_mean;
                    n_out_peak  = '0;
                    n_out_touch = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_margin    <= SAMPLE_W'(100);
            r_short     <= GCOUNT_W'(3);
            r_long      <= GCOUNT_W'(6);
            r_cal_count <= '0;
            r_baseline  <= '0;
            r_gmax      <= '0;
            r_gcount    <= '0;
            r_gtarget   <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_margin    <= n_margin;
            r_short     <= n_short;
            r_long      <= n_long;
            r_cal_count <= n_cal_count;
            r_baseline  <= n_baseline;
            r_gmax      <= n_gmax;
            r_gcount    <= n_gcount;
            r_gtarget   <= n_gtarget;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
        r_acc       <= n_acc;
        r_out_kind  <= n_out_kind;
        r_out_base  <= n_out_base;
        r_out_peak  <= n_out_peak;
        r_out_touch <= n_out_touch;
    end

    // ---------------------------------------------------------------
    // Result word
    // ---------------------------------------------------------------
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tuser[0] = r_out_kind;
    assign o_m_tdata    = {7'd0, r_out_touch, r_out_peak, r_out_base};

endmodule

>>> test/touch_pad_baseline_and_detect_test.sv
`timescale 1ns / 1ps

module touch_pad_baseline_and_detect_test;

    import tpbd_pkg::*;

    // Must match the block's default parameters
    localparam int CAL_N    = 10;
    localparam int TRIM     = 2;
    // A wait that outlasts the hold after the last word of a calibration set
    localparam int HOLD_OFF = 48;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        logic        long_scan;
    } t_pad_word;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] baseline;
        logic [15:0] peak;
        logic        touched;
    } t_pad_result;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [15:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GATE_MARGIN;
    logic [15:0]          cfg_data  = '0;

    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire  [39:0]          o_m_tdata;
    wire  [0:0]           o_m_tuser;
    wire                  o_cfg_ready;

    touch_pad_baseline_and_detect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),      // [15:0] sample
        .i_s_tuser   (s_tuser),      // [0] kind, [1] long_scan
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),    // [15:0] baseline, [31:16] peak, [32] touched
        .o_m_tuser   (o_m_tuser),    // [0] result_kind
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the pad's calibration and scan
    // state plus its registers, advanced once per accepted word.
    // ------------------------------------------------------------------
    logic [15:0] cfg_margin = 16'd100;
    logic [3:0]  cfg_short  = 4'd3;
    logic [3:0]  cfg_long   = 4'd6;

    logic [15:0] cal_sorted [CAL_N];
    int          cal_fill     = 0;
    logic [15:0] pad_baseline = '0;
    logic [15:0] grp_peak     = '0;
    int          grp_seen     = 0;
    int          grp_target   = 0;

    t_pad_word   word_queue [$];     // words waiting for the driver
    t_pad_result due_results [$];    // results the block still owes
    t_pad_word   on_bus;             // word currently offered
    int          words_queued = 0;
    int          words_taken  = 0;
    int          errors       = 0;
    bit          calm         = 1'b0; // no idling on either side while set

    // Advance the predicted state by one accepted word.
    task automatic absorb_word(input t_pad_word w);
        int          pos;
        logic [31:0] sum;
        logic [16:0] limit;
        t_pad_result r;
        if (w.kind == KIND_CAL) begin
            // sorted insert into the calibration set
            if (cal_fill < CAL_N) begin
                pos = cal_fill;
                while (pos > 0 && cal_sorted[pos-1] > w.sample) begin
                    cal_sorted[pos] = cal_sorted[pos-1];
                    pos--;
                end
                cal_sorted[pos] = w.sample;
                cal_fill++;
            end
            if (cal_fill >= CAL_N) begin
                // trimmed mean; nothing left after trimming gives zero
                if (2 * TRIM >= CAL_N) begin
                    pad_baseline = '0;
                end else begin
                    sum = '0;
                    for (int i = TRIM; i < CAL_N - TRIM; i++)
                        sum += 32'(cal_sorted[i]);
                    pad_baseline = 16'(sum / (CAL_N - 2 * TRIM));
                end
                cal_fill      = 0;
                r.result_kind = KIND_CAL;
                r.baseline    = pad_baseline;
                r.peak        = '0;
                r.touched     = 1'b0;
                due_results.push_back(r);
            end
        end else begin
            // the first word of a group fixes its length; a count of zero acts as one
            if (grp_seen == 0) begin
                grp_target = w.long_scan ? int'(cfg_long) : int'(cfg_short);
                if (grp_target == 0)
                    grp_target = 1;
                grp_peak = w.sample;
            end else if (w.sample > grp_peak) begin
                grp_peak = w.sample;
            end
            grp_seen++;
            if (grp_seen >= grp_target) begin
                // compare at 17 bits so baseline plus margin cannot wrap
                limit         = {1'b0, pad_baseline} + {1'b0, cfg_margin};
                r.result_kind = KIND_SCAN;
                r.baseline    = pad_baseline;
                r.peak        = grp_peak;
                r.touched     = ({1'b0, grp_peak} > limit);
                due_results.push_back(r);
                grp_seen = 0;
                grp_peak = '0;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 14);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued words, predicts on every accepted word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                absorb_word(on_bus);
                words_taken++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (word_queue.size() != 0 && !take_break()) begin
                    on_bus = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.sample;
                    s_tuser  <= {on_bus.long_scan, on_bus.kind};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, each result word against the oldest due.
    // ------------------------------------------------------------------
    task automatic check_result();
        t_pad_result want;
        if (due_results.size() == 0) begin
            report("result word with nothing due", 32'(o_m_tuser[0]), 32'd0);
        end else begin
            want = due_results.pop_front();
            if (o_m_tuser[0] !== want.result_kind)
                report("result_kind", 32'(o_m_tuser[0]), 32'(want.result_kind));
            if (o_m_tdata[15:0] !== want.baseline)
                report("baseline", 32'(o_m_tdata[15:0]), 32'(want.baseline));
            if (o_m_tdata[31:16] !== want.peak)
                report("peak", 32'(o_m_tdata[31:16]), 32'(want.peak));
            if (o_m_tdata[32] !== want.touched)
                report("touched", 32'(o_m_tdata[32]), 32'(want.touched));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready)
                check_result();
            m_tready <= !take_break();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic kind, input logic [15:0] sample, input logic lng);
        t_pad_word w;
        w.kind      = kind;
        w.sample    = sample;
        w.long_scan = lng;
        word_queue.push_back(w);
        words_queued++;
    endtask

    function automatic logic [15:0] clamp16(input int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    // Register write; only called with the pad idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GATE_MARGIN: cfg_margin = value;
            REG_SHORT_COUNT: cfg_short  = value[3:0];
            REG_LONG_COUNT:  cfg_long   = value[3:0];
            default: ;
        endcase
    endtask

    // Hold the sender until every word is taken and every result has come,
    // then let a calibration hold run out.
    task automatic settle();
        do @(posedge i_clk);
        while (words_taken != words_queued || due_results.size() != 0);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: calibration sets clustered round a level,
    // scan groups of the configured length aimed at the touch threshold,
    // and a share of random words that break groups and sets apart.
    task automatic random_phase(input int n_words);
        int       done;
        int       pick;
        int       level;
        int       len;
        int       val;
        bit       lng;
        done  = 0;
        level = $urandom_range(60000, 200);
        while (done < n_words) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(3) == 0)
                    level = $urandom_range(65535, 0);
                for (int k = 0; k < CAL_N; k++) begin
                    val = level + $urandom_range(64, 0) - 32;
                    if ($urandom_range(9) == 0)
                        val = $urandom_range(65535, 0);
                    queue_word(KIND_CAL, clamp16(val), 1'($urandom_range(1)));
                end
                done += CAL_N;
            end else if (pick < 85) begin
                lng = 1'($urandom_range(1));
                len = lng ? int'(cfg_long) : int'(cfg_short);
                if (len == 0)
                    len = 1;
                for (int k = 0; k < len; k++) begin
                    val = level + int'(cfg_margin) + $urandom_range(12, 0) - 6;
                    if ($urandom_range(4) == 0)
                        val = $urandom_range(65535, 0);
                    queue_word(KIND_SCAN, clamp16(val),
                               (k == 0) ? lng : 1'($urandom_range(1)));
                end
                done += len;
            end else begin
                queue_word(1'($urandom_range(1)), 16'($urandom_range(65535, 0)),
                           1'($urandom_range(1)));
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, default registers (margin 100, groups of 3 and 6).
        // Scan before any calibration: baseline is still zero.
        queue_word(KIND_SCAN, 16'd0,     1'b0);
        queue_word(KIND_SCAN, 16'hFFFF,  1'b0);
        queue_word(KIND_SCAN, 16'd50,    1'b1);
        // peak equal to baseline plus margin is not a touch
        queue_word(KIND_SCAN, 16'd100,   1'b0);
        queue_word(KIND_SCAN, 16'd20,    1'b1);
        queue_word(KIND_SCAN, 16'd7,     1'b0);
        // long group with a calibration word in the middle of it
        queue_word(KIND_SCAN, 16'd300,   1'b1);
        queue_word(KIND_SCAN, 16'd5,     1'b0);
        queue_word(KIND_CAL,  16'hFFFF,  1'b1);
        queue_word(KIND_SCAN, 16'd400,   1'b0);
        queue_word(KIND_SCAN, 16'd0,     1'b1);
        queue_word(KIND_SCAN, 16'hFFFF,  1'b0);
        queue_word(KIND_SCAN, 16'd2,     1'b0);
        // rest of the calibration set, out of order, extremes at both ends
        queue_word(KIND_CAL,  16'd0,     1'b0);
        queue_word(KIND_CAL,  16'd900,   1'b1);
        queue_word(KIND_CAL,  16'd800,   1'b0);
        queue_word(KIND_CAL,  16'd1200,  1'b0);
        queue_word(KIND_CAL,  16'd1000,  1'b1);
        queue_word(KIND_CAL,  16'd700,   1'b0);
        queue_word(KIND_CAL,  16'd1100,  1'b0);
        queue_word(KIND_CAL,  16'hFFFF,  1'b0);
        queue_word(KIND_CAL,  16'd950,   1'b1);
        // baseline 991: a peak of 1092 is just over the threshold
        queue_word(KIND_SCAN, 16'd1000,  1'b0);
        queue_word(KIND_SCAN, 16'd1092,  1'b1);
        queue_word(KIND_SCAN, 16'd1091,  1'b0);
        settle();

        // Register settings, extremes first; zero group counts act as one
        write_reg(REG_GATE_MARGIN, 16'd0);
        write_reg(REG_SHORT_COUNT, 16'd1);
        write_reg(REG_LONG_COUNT,  16'd15);
        random_phase(110);
        settle();

        write_reg(REG_GATE_MARGIN, 16'hFFFF);
        write_reg(REG_SHORT_COUNT, 16'd15);
        write_reg(REG_LONG_COUNT,  16'd1);
        random_phase(110);
        settle();

        // long stretch with no idling on either side
        calm = 1'b1;
        write_reg(REG_GATE_MARGIN, 16'd0);
        write_reg(REG_SHORT_COUNT, 16'd0);
        write_reg(REG_LONG_COUNT,  16'd0);
        random_phase(110);
        settle();
        calm = 1'b0;

        write_reg(REG_GATE_MARGIN, 16'($urandom_range(400, 0)));
        write_reg(REG_SHORT_COUNT, 16'($urandom_range(15, 1)));
        write_reg(REG_LONG_COUNT,  16'($urandom_range(15, 1)));
        random_phase(110);
        settle();

        write_reg(REG_GATE_MARGIN, 16'd100);
        write_reg(REG_SHORT_COUNT, 16'd3);
        write_reg(REG_LONG_COUNT,  16'd6);
        random_phase(110);
        settle();

        if (errors == 0) begin
            $display("PASS touch_pad_baseline_and_detect");
        end else begin
            $display("FAIL touch_pad_baseline_and_detect");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAIL touch_pad_baseline_and_detect");
        $finish;
    end

endmodule
